### src/isu_pkg.sv
package isu_pkg;

  localparam int TIME_BITS = 48;
  localparam int FRAC_BITS = 16;
  localparam int AXIS_BITS = 32;
  localparam int NUM_AXES  = 3;
  localparam int Q_DEPTH   = 2;

  localparam int DIV_CNT_W = $clog2(FRAC_BITS);
  localparam int AXIS_IDX_W = $clog2(NUM_AXES);
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // diff (AXIS_BITS+1) times signed factor (FRAC_BITS+2)
  localparam int PROD_W = AXIS_BITS + FRAC_BITS + 3;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic SENSOR_GYRO  = 1'b0;
  localparam logic SENSOR_ACCEL = 1'b1;

  localparam logic [1:0] FILL_FULL = 2'd2;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [AXIS_BITS-1:0] axis_t;
  typedef axis_t [NUM_AXES-1:0] vec_t;
  typedef logic [FRAC_BITS:0]   frac_t;

  localparam frac_t FRAC_ONE = frac_t'(1) << FRAC_BITS;

  typedef struct packed {
    logic  accel_slow;
    time_t t_old;
    time_t t_new;
    time_t t_fast;
    vec_t  old_v;
    vec_t  new_v;
    vec_t  fast_v;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic finish;
  } bk_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_DIV,
    BK_MUL,
    BK_ACC,
    BK_DONE
  } bk_state_t;

endpackage

### src/isu_if.sv
interface isu_in_if;
  import isu_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        sensor_id;
  logic        [TIME_BITS-1:0] sample_time;
  logic signed [AXIS_BITS-1:0] axis_x;
  logic signed [AXIS_BITS-1:0] axis_y;
  logic signed [AXIS_BITS-1:0] axis_z;

  modport source (output valid, sensor_id, sample_time, axis_x, axis_y, axis_z,
                  input ready);
  modport sink (input valid, sensor_id, sample_time, axis_x, axis_y, axis_z,
                output ready);
endinterface

interface isu_out_if;
  import isu_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [AXIS_BITS-1:0] gyro_x;
  logic signed [AXIS_BITS-1:0] gyro_y;
  logic signed [AXIS_BITS-1:0] gyro_z;
  logic signed [AXIS_BITS-1:0] accel_x;
  logic signed [AXIS_BITS-1:0] accel_y;
  logic signed [AXIS_BITS-1:0] accel_z;
  logic        [TIME_BITS-1:0] aligned_time;

  modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                  aligned_time, input ready);
  modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                aligned_time, output ready);
endinterface

### src/isu_queue.sv
module isu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  isu_pkg::job_t       push_job,
  input  logic                pop,
  output isu_pkg::job_t       pop_job,
  output isu_pkg::q_status_t  q_st
);
  import isu_pkg::*;

  job_t                 entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;

  assign pop_job  = entry_r[rd_ptr_r];
  assign q_st.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_st.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### src/isu_front.sv
module isu_front (
  input  logic               clk,
  input  logic               rst_n,
  isu_in_if.sink             in_ch,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  isu_pkg::q_status_t q_st,
  output logic               push,
  output isu_pkg::job_t      push_job
);
  import isu_pkg::*;

  logic       accel_slow_r;
  logic [1:0] fill_r [2];
  time_t      time_r [2][2];   // [sensor][slot], slot 0 old, 1 recent
  vec_t       vec_r  [2][2];

  logic       accept;
  logic       is_slow;
  vec_t       in_vec;
  time_t      slow_recent_t;
  time_t      fast_recent_t;
  vec_t       slow_recent_v;
  vec_t       fast_recent_v;
  logic [1:0] slow_fill;
  logic [1:0] fast_fill;
  logic       hist_ok;
  logic       in_window;

  assign in_ch.ready = !q_st.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_vec      = {in_ch.axis_z, in_ch.axis_y, in_ch.axis_x};

  assign is_slow = (in_ch.sensor_id == (accel_slow_r ? SENSOR_ACCEL : SENSOR_GYRO));

  assign slow_recent_t = accel_slow_r ? time_r[SENSOR_ACCEL][1] : time_r[SENSOR_GYRO][1];
  assign fast_recent_t = accel_slow_r ? time_r[SENSOR_GYRO][1]  : time_r[SENSOR_ACCEL][1];
  assign slow_recent_v = accel_slow_r ? vec_r[SENSOR_ACCEL][1]  : vec_r[SENSOR_GYRO][1];
  assign fast_recent_v = accel_slow_r ? vec_r[SENSOR_GYRO][1]   : vec_r[SENSOR_ACCEL][1];
  assign slow_fill     = accel_slow_r ? fill_r[SENSOR_ACCEL]    : fill_r[SENSOR_GYRO];
  assign fast_fill     = accel_slow_r ? fill_r[SENSOR_GYRO]     : fill_r[SENSOR_ACCEL];

  // slow history is full once this sample lands if it already held one
  assign hist_ok   = (slow_fill != 2'd0) && (fast_fill == FILL_FULL);
  assign in_window = (fast_recent_t >= slow_recent_t) && (fast_recent_t <= in_ch.sample_time);

  assign push = accept && is_slow && hist_ok && in_window;

  always_comb begin
    push_job.accel_slow = accel_slow_r;
    push_job.t_old      = slow_recent_t;
    push_job.t_new      = in_ch.sample_time;
    push_job.t_fast     = fast_recent_t;
    push_job.old_v      = slow_recent_v;
    push_job.new_v      = in_vec;
    push_job.fast_v     = fast_recent_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_slow_r <= 1'b1;
      fill_r[0]    <= '0;
      fill_r[1]    <= '0;
    end else begin
      if (cfg_we) begin
        accel_slow_r <= cfg_wdata;
      end
      for (int k = 0; k < 2; k++) begin
        if (accept && (in_ch.sensor_id == 1'(k)) && (fill_r[k] != FILL_FULL)) begin
          fill_r[k] <= fill_r[k] + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      if (accept && (in_ch.sensor_id == 1'(k))) begin
        time_r[k][0] <= time_r[k][1];
        time_r[k][1] <= in_ch.sample_time;
        vec_r[k][0]  <= vec_r[k][1];
        vec_r[k][1]  <= in_vec;
      end
    end
  end

endmodule

### src/isu_back.sv
module isu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  isu_pkg::q_status_t  q_st,
  input  isu_pkg::job_t       pop_job,
  output logic                pop,
  isu_out_if.source           out_ch,
  output isu_pkg::bk_status_t bk_st
);
  import isu_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

  bk_state_t               state_r;
  bk_state_t               state_nxt;
  job_t                    job_r;
  time_t                   num_r;
  time_t                   den_r;
  logic [TIME_BITS:0]      rem_r;
  frac_t                   quo_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic [AXIS_IDX_W-1:0]   idx_r;
  logic signed [PROD_W-1:0] prod_r;
  vec_t                    res_r;
  logic                    out_valid_r;
  vec_t                    out_gyro_r;
  vec_t                    out_accel_r;
  time_t                   out_time_r;

  logic                    out_free;
  logic                    out_load;
  logic [TIME_BITS:0]      rem_shift;
  logic                    sub_ok;
  axis_t                   old_a;
  axis_t                   new_a;
  logic signed [AXIS_BITS:0]  diff_w;
  logic signed [FRAC_BITS+1:0] fac_w;
  logic signed [PROD_W-1:0]   mul_w;
  logic signed [SUM_W-1:0]    base_w;
  logic signed [SUM_W-1:0]    sum_w;
  logic signed [SUM_W-1:0]    shr_w;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (!q_st.empty) state_nxt = BK_CHECK;
      BK_CHECK: state_nxt = (num_r >= den_r) ? BK_MUL : BK_DIV;
      BK_DIV:   if (cnt_r == DIV_CNT_W'(FRAC_BITS - 1)) state_nxt = BK_MUL;
      BK_MUL:   state_nxt = BK_ACC;
      BK_ACC:   state_nxt = (idx_r == AXIS_IDX_W'(NUM_AXES - 1)) ? BK_DONE : BK_MUL;
      BK_DONE:  if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      BK_IDLE: pop      = !q_st.empty;
      BK_DONE: out_load = out_free;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
    bk_st.busy   = (state_r != BK_IDLE);
    bk_st.finish = out_load;
  end

  // restoring divide step, remainder stays below den
  assign rem_shift = {rem_r[TIME_BITS-1:0], 1'b0};
  assign sub_ok    = (rem_shift >= {1'b0, den_r});

  // axis = (old * 2^F + (new - old) * f + half) >>> F
  assign old_a  = job_r.old_v[idx_r];
  assign new_a  = job_r.new_v[idx_r];
  assign diff_w = $signed({new_a[AXIS_BITS-1], new_a}) - $signed({old_a[AXIS_BITS-1], old_a});
  assign fac_w  = $signed({1'b0, quo_r});
  assign mul_w  = diff_w * fac_w;
  assign base_w = $signed({{(SUM_W - AXIS_BITS - FRAC_BITS){old_a[AXIS_BITS-1]}},
                           old_a, {FRAC_BITS{1'b0}}});
  assign sum_w  = base_w + $signed({prod_r[PROD_W-1], prod_r}) + ROUND_HALF;
  assign shr_w  = sum_w >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= pop_job;
      num_r <= pop_job.t_fast - pop_job.t_old;
      den_r <= pop_job.t_new - pop_job.t_old;
    end
    case (state_r)
      BK_CHECK: begin
        rem_r <= {1'b0, num_r};
        quo_r <= (num_r >= den_r) ? FRAC_ONE : '0;
        cnt_r <= '0;
        idx_r <= '0;
      end
      BK_DIV: begin
        rem_r <= sub_ok ? (rem_shift - {1'b0, den_r}) : rem_shift;
        quo_r <= {quo_r[FRAC_BITS-1:0], sub_ok};
        cnt_r <= cnt_r + 1'b1;
      end
      BK_MUL: begin
        prod_r <= mul_w;
      end
      BK_ACC: begin
        res_r[idx_r] <= shr_w[AXIS_BITS-1:0];
        idx_r        <= idx_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_gyro_r  <= job_r.accel_slow ? job_r.fast_v : res_r;
      out_accel_r <= job_r.accel_slow ? res_r : job_r.fast_v;
      out_time_r  <= job_r.t_fast;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.gyro_x       = out_gyro_r[0];
  assign out_ch.gyro_y       = out_gyro_r[1];
  assign out_ch.gyro_z       = out_gyro_r[2];
  assign out_ch.accel_x      = out_accel_r[0];
  assign out_ch.accel_y      = out_accel_r[1];
  assign out_ch.accel_z      = out_accel_r[2];
  assign out_ch.aligned_time = out_time_r;

endmodule

### src/imu_stream_interpolating_sync_unit.sv
// channel   dir   handshake          payload
// in_ch     in    valid/ready        sensor_id, sample_time, axis_x/y/z
// out_ch    out   valid/ready        gyro_x/y/z, accel_x/y/z, aligned_time
// cfg       in    cfg_we (no ready)  cfg_wdata = accel_is_slow
//
// Every sample is accepted whenever the two-entry job queue has room.
// A slow-sensor sample that qualifies takes the back end through these steps
// in order: take the job, check it, 16 steps of the serial divider (skipped
// when the fast timestamp equals the new slow one), one multiply and one add
// per axis, then load the result register.
// rst_n is synchronous: histories empty, accel_is_slow = 1, queue and output
// cleared. The result register lets the back end compute the next job while
// out_ch stalls, but not load it; input stalls only when the queue is full.
module imu_stream_interpolating_sync_unit (
  input  logic       clk,
  input  logic       rst_n,
  isu_in_if.sink     in_ch,
  isu_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import isu_pkg::*;

  logic       push;
  job_t       push_job;
  logic       pop;
  job_t       pop_job;
  q_status_t  q_st;
  bk_status_t bk_st;

  isu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_st     (q_st),
    .push     (push),
    .push_job (push_job)
  );

  isu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .q_st    (q_st)
  );

  isu_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_st   (q_st),
    .pop_job(pop_job),
    .pop    (pop),
    .out_ch (out_ch),
    .bk_st  (bk_st)
  );

`ifndef NO_ASSERTIONS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_st.full)
    else $error("job pushed into full queue");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_st.empty)
    else $error("job popped from empty queue");

  a_out_from_back: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(bk_st.finish))
    else $error("result appeared without a finished job");

  a_pop_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> bk_st.busy)
    else $error("back end idle after taking a job");
`endif

endmodule
